### rtl/fdiv_pkg.sv
`timescale 1ns / 1ps

package fdiv_pkg;

    localparam int DataW     = 32;
    localparam int FracBits  = 16;
    localparam int TestShift = 14;
    // quotient magnitude stays below 2**(TestShift+FracBits) once saturation is ruled out
    localparam int QuoBits   = TestShift + FracBits;
    // partial remainder stays below the divisor magnitude, which is at most 2**(DataW-1)
    localparam int RemW      = DataW - 1;
    // input reg + magnitude + saturation test + one stage per quotient bit + output reg
    localparam int Latency   = QuoBits + 4;

    localparam logic [DataW-1:0] SatPos = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] SatNeg = {1'b1, {(DataW-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic sat;
        logic neg;
    } fdiv_ctl_t;

endpackage

### rtl/fdiv_step.sv
`timescale 1ns / 1ps

module fdiv_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fdiv_pkg::fdiv_ctl_t          ctl_in,
    input  logic [fdiv_pkg::RemW-1:0]    rem_in,
    input  logic [fdiv_pkg::QuoBits-1:0] qn_in,
    input  logic [fdiv_pkg::DataW-1:0]   mb_in,
    output fdiv_pkg::fdiv_ctl_t          ctl_out,
    output logic [fdiv_pkg::RemW-1:0]    rem_out,
    output logic [fdiv_pkg::QuoBits-1:0] qn_out,
    output logic [fdiv_pkg::DataW-1:0]   mb_out
);
    import fdiv_pkg::*;

    logic [DataW-1:0]   r2;
    logic [DataW:0]     diff;
    logic               take;
    logic [RemW-1:0]    rem_next;
    logic [QuoBits-1:0] qn_next;
    fdiv_ctl_t          ctl_reg;
    logic [RemW-1:0]    rem_reg;
    logic [QuoBits-1:0] qn_reg;
    logic [DataW-1:0]   mb_reg;

    // restoring step: bring down next numerator bit, trial subtract
    always_comb
    begin
        r2       = {rem_in, qn_in[QuoBits-1]};
        diff     = {1'b0, r2} - {1'b0, mb_in};
        take     = ~diff[DataW];
        rem_next = take ? diff[RemW-1:0] : r2[RemW-1:0];
        qn_next  = {qn_in[QuoBits-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qn_reg  <= qn_next;
        mb_reg  <= mb_in;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign qn_out  = qn_reg;
    assign mb_out  = mb_reg;

endmodule

### rtl/fixed_div_16_16_saturating.sv
`timescale 1ns / 1ps

// Signed 16.16 fixed-point divider with saturation.
//
// Input channel: dividend and divisor are taken as one beat at each rising
// edge where start is high and busy is low. busy is always low, so a new
// beat can be taken in every cycle.
// Output channel: quotient is valid for exactly one cycle while done is high.
// There is no backpressure; the receiver must take each beat as it comes.
//
// Path: an accepted beat passes the input reg, magnitude, saturation test, 30
// restoring steps and output reg; done rises as it leaves the output reg.
// Throughput: one beat per cycle. Each quotient bit has its own stage, so up
// to 34 divides are in flight at once.
//
// Overflow: when |dividend| >>> 14 >= |divisor| (arithmetic shift, unsigned compare) the result clamps
// to the most negative value if the signs differ, else the most positive.
// This covers divide by zero and a most-negative dividend.
// Otherwise the result is (dividend << 16) / divisor, truncated toward zero.
//
// Reset (rst_n low, async): all valid bits clear; in-flight beats are dropped.
module fixed_div_16_16_saturating (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [fdiv_pkg::DataW-1:0] dividend,
    input  logic signed [fdiv_pkg::DataW-1:0] divisor,
    output logic                              done,
    output logic signed [fdiv_pkg::DataW-1:0] quotient
);
    import fdiv_pkg::*;

    logic             accept;

    // stage 0: raw operands
    logic             in_valid_reg;
    logic [DataW-1:0] a_reg;
    logic [DataW-1:0] b_reg;

    // stage 1: magnitudes
    logic             mag_valid_reg;
    logic             mag_neg_reg;
    logic [DataW-1:0] ma_reg;
    logic [DataW-1:0] mb_reg;
    logic [DataW-1:0] ma_next;
    logic [DataW-1:0] mb_next;

    // stage 2 onward: divider chain, index 0 is the saturation-test stage
    fdiv_ctl_t          ctl_pipe [0:QuoBits];
    logic [RemW-1:0]    rem_pipe [0:QuoBits];
    logic [QuoBits-1:0] qn_pipe  [0:QuoBits];
    logic [DataW-1:0]   mb_pipe  [0:QuoBits];

    fdiv_ctl_t          ctl_next;
    logic [RemW-1:0]    rem_init;
    logic [QuoBits-1:0] qn_init;

    // output stage
    logic             done_reg;
    logic [DataW-1:0] quo_reg;
    logic [DataW-1:0] mag_out;
    logic [DataW-1:0] quo_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mag_valid_reg <= 1'b0;
            ctl_pipe[0]   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            mag_valid_reg <= in_valid_reg;
            ctl_pipe[0]   <= ctl_next;
            done_reg      <= ctl_pipe[QuoBits].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= dividend;
        b_reg       <= divisor;
        mag_neg_reg <= a_reg[DataW-1] ^ b_reg[DataW-1];
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        rem_pipe[0] <= rem_init;
        qn_pipe[0]  <= qn_init;
        mb_pipe[0]  <= mb_reg;
        quo_reg     <= quo_next;
    end

    // two's-complement magnitude; the most negative value maps to itself
    always_comb
    begin
        ma_next = a_reg[DataW-1] ? (DataW'(0) - a_reg) : a_reg;
        mb_next = b_reg[DataW-1] ? (DataW'(0) - b_reg) : b_reg;
    end

    // Saturation test. A magnitude with the top bit set shifts arithmetically
    // to at least 0xFFFE0000, which beats any divisor magnitude.
    // The shifted dividend is also the first partial remainder; the low
    // dividend bits followed by the fraction zeros feed the steps below.
    always_comb
    begin
        ctl_next.valid = mag_valid_reg;
        ctl_next.neg   = mag_neg_reg;
        ctl_next.sat   = ma_reg[DataW-1]
                       | ({{TestShift{1'b0}}, ma_reg[DataW-1:TestShift]} >= mb_reg);
        rem_init       = RemW'(ma_reg[DataW-2:TestShift]);
        qn_init        = {ma_reg[TestShift-1:0], {FracBits{1'b0}}};
    end

    // one quotient bit per stage, MSB first
    for (genvar i = 0; i < QuoBits; i++)
    begin : g_step
        fdiv_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_pipe[i]),
            .rem_in  (rem_pipe[i]),
            .qn_in   (qn_pipe[i]),
            .mb_in   (mb_pipe[i]),
            .ctl_out (ctl_pipe[i+1]),
            .rem_out (rem_pipe[i+1]),
            .qn_out  (qn_pipe[i+1]),
            .mb_out  (mb_pipe[i+1])
        );
    end

    // apply sign, or clamp
    always_comb
    begin
        mag_out = DataW'(qn_pipe[QuoBits]);
        if (ctl_pipe[QuoBits].sat)
        begin
            quo_next = ctl_pipe[QuoBits].neg ? SatNeg : SatPos;
        end
        else
        begin
            quo_next = ctl_pipe[QuoBits].neg ? (DataW'(0) - mag_out) : mag_out;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/fdiv_chk.sv
`timescale 1ns / 1ps

module fdiv_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic signed [fdiv_pkg::DataW-1:0] dividend,
    input logic signed [fdiv_pkg::DataW-1:0] divisor,
    input logic                              done,
    input logic signed [fdiv_pkg::DataW-1:0] quotient
);
    import fdiv_pkg::*;

    // every accepted beat comes out after a fixed latency
    a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Latency done)
        else $error("accepted beat did not produce a result");

    // no result without a matching accepted beat
    a_lat_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##Latency !done)
        else $error("result without accepted beat");

    // zero divisor with nonnegative dividend clamps high
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && divisor == '0 && !dividend[DataW-1])
        |-> ##Latency (quotient == SatPos))
        else $error("divide by zero did not clamp");

    // zero dividend over a nonzero divisor gives zero
    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && dividend == '0 && divisor != '0)
        |-> ##Latency (quotient == '0))
        else $error("zero dividend gave nonzero quotient");

endmodule

bind fixed_div_16_16_saturating fdiv_chk u_fdiv_chk (.*);

### dv/fixed_div_16_16_saturating_tb.sv
`timescale 1ns / 1ps

// Scoreboard testbench for the 16.16 saturating divider.
// Operand beats go in through start/busy; quotient beats come back on done
// and are matched in order against a predicted queue.
module fixed_div_16_16_saturating_tb;

    import fdiv_pkg::*;

    // Cycles with no beat moving in either direction before the run is abandoned.
    // Worst honest gap is a sender idle stretch plus a full pipeline flush.
    localparam int StallLimit = 2000;

    localparam logic [DataW-1:0] OneFix    = 32'h0001_0000;
    localparam logic [DataW-1:0] MinusOne  = 32'hFFFF_0000;

    typedef enum int {
        MIX_FULL,
        MIX_SMALL_DEN,
        MIX_SAT_EDGE,
        MIX_SPECIAL,
        MIX_NARROW
    } operand_mix_e;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             start    = 1'b0;
    logic [DataW-1:0] dividend = '0;
    logic [DataW-1:0] divisor  = '0;
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;

    // quotients predicted for accepted beats, oldest first
    logic [DataW-1:0] pending_quotients[$];

    int beats_sent;
    int quotients_checked;
    int saturations_seen;
    int mismatches;
    int idle_cycles = 0;
    int sender_gap_pct;

    logic [DataW-1:0] special_vals[8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, SatPos,
        SatNeg, OneFix, MinusOne, 32'h0000_4000
    };

    fixed_div_16_16_saturating dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient)
    );

    always #10 clk = ~clk;

    // Bit-exact quotient prediction.
    // Magnitudes are 32-bit negations, so the most negative value maps to itself;
    // the overflow test shifts the dividend magnitude arithmetically, which makes
    // a most-negative dividend always clamp.
    function automatic logic [DataW-1:0] divide_16_16(logic [DataW-1:0] num,
                                                      logic [DataW-1:0] den);
        logic [DataW-1:0]  num_mag;
        logic [DataW-1:0]  den_mag;
        logic [DataW-1:0]  scaled;
        logic signed [63:0] wide_num;
        logic signed [63:0] wide_den;
        logic signed [63:0] wide_quo;
        num_mag = num[DataW-1] ? -num : num;
        den_mag = den[DataW-1] ? -den : den;
        scaled  = $signed(num_mag) >>> TestShift;
        if (scaled >= den_mag)
            return (num[DataW-1] ^ den[DataW-1]) ? SatNeg : SatPos;
        // den is nonzero here; SV signed division truncates toward zero
        wide_num = $signed(num);
        wide_num = wide_num <<< FracBits;
        wide_den = $signed(den);
        wide_quo = wide_num / wide_den;
        return wide_quo[DataW-1:0];
    endfunction

    function automatic logic [DataW-1:0] random_sign(logic [DataW-1:0] mag);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // One operand beat. start stays high on return so back-to-back beats
    // never lower and raise it in the same step.
    // Each cycle the sender idles with chance sender_gap_pct in a hundred.
    task automatic issue_divide(logic [DataW-1:0] num, logic [DataW-1:0] den);
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_quotients.push_back(divide_16_16(num, den));
        beats_sent++;
    endtask

    // Hold the input off until every outstanding quotient has been returned.
    task automatic wait_for_quotients();
        start <= 1'b0;
        @(posedge clk);
        while (pending_quotients.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_operand_extremes();
        issue_divide(32'h0, OneFix);
        issue_divide(SatPos, SatPos);
        issue_divide(SatNeg, 32'h1);          // most negative dividend clamps
        issue_divide(SatNeg, SatNeg);
        issue_divide(SatPos, SatNeg);         // most negative divisor divides normally
        issue_divide(32'h1, SatNeg);
        issue_divide(32'hFFFF_FFFF, SatNeg);
        issue_divide(32'h0, SatNeg);
        issue_divide(32'h0, 32'h0);           // zero by zero gives most positive
        issue_divide(32'h5, 32'h0);
        issue_divide(32'hFFFF_FFFB, 32'h0);   // negative by zero gives most negative
        issue_divide(32'hAAAA_5555, 32'h5555_AAAA);
    endtask

    task automatic test_saturation_edge();
        // |1.0| >> 14 = 4: divisor magnitude 4 clamps, 5 divides
        issue_divide(OneFix, 32'h4);
        issue_divide(OneFix, 32'h5);
        issue_divide(MinusOne, 32'h4);
        issue_divide(MinusOne, 32'hFFFF_FFFB);
        issue_divide(OneFix, 32'hFFFF_FFFC);
        issue_divide(32'h7FFF_C000, 32'h0001_FFFF);
        issue_divide(32'h7FFF_C000, 32'h0002_0000);
    endtask

    task automatic test_truncation_signs();
        issue_divide(32'h0000_0003, 32'h0002_0000);
        issue_divide(32'hFFFF_FFFD, 32'h0002_0000);
        issue_divide(32'h0003_0000, 32'hFFFE_0000);
        issue_divide(32'hFFFD_0000, 32'hFFFE_0000);
        issue_divide(32'h0001_0000, 32'h0003_0000);
    endtask

    task automatic pick_operands(output logic [DataW-1:0] num, output logic [DataW-1:0] den);
        operand_mix_e     mix;
        logic [DataW-1:0] den_mag;
        mix = operand_mix_e'($urandom_range(0, 4));
        case (mix)
            MIX_FULL:
            begin
                num = $urandom;
                den = $urandom;
            end
            MIX_SMALL_DEN:
            begin
                num = $urandom;
                den = random_sign($urandom_range(0, 32'h3_FFFF));
            end
            MIX_SAT_EDGE:
            begin
                // dividend magnitude straddles the clamp threshold for this divisor
                den_mag = $urandom_range(1, 32'h1_FFFF);
                num = random_sign((den_mag << TestShift) + $urandom_range(0, 32767) - 16384);
                den = random_sign(den_mag);
            end
            MIX_SPECIAL:
            begin
                num = $urandom_range(0, 1) ? special_vals[$urandom_range(0, 7)] : $urandom;
                den = $urandom_range(0, 1) ? special_vals[$urandom_range(0, 7)] : $urandom;
            end
            default:
            begin
                num = {{16{1'b0}}, 16'($urandom)};
                num = $signed(num[15:0]);
                den = {{16{1'b0}}, 16'($urandom)};
                den = $signed(den[15:0]);
            end
        endcase
    endtask

    task automatic test_random_mix(int count, int gap_pct);
        logic [DataW-1:0] num;
        logic [DataW-1:0] den;
        sender_gap_pct = gap_pct;
        repeat (count)
        begin
            pick_operands(num, den);
            issue_divide(num, den);
        end
        wait_for_quotients();
    endtask

    // Result side: done marks a single-cycle beat that must be taken as it comes.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_quotients.size() == 0)
            begin
                $error("quotient: no divide outstanding, got %h", quotient);
                mismatches++;
            end
            else
            begin
                logic [DataW-1:0] want;
                want = pending_quotients.pop_front();
                if (quotient !== want)
                begin
                    $error("quotient: expected %h, actual %h", want, quotient);
                    mismatches++;
                end
                if (want == SatPos || want == SatNeg)
                    saturations_seen++;
                quotients_checked++;
            end
        end
    end

    // Watchdog: any beat moving either way resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= StallLimit)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        beats_sent        = 0;
        quotients_checked = 0;
        saturations_seen  = 0;
        mismatches        = 0;
        sender_gap_pct    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part goes back to back, then drains fully once
        test_operand_extremes();
        test_saturation_edge();
        test_truncation_signs();
        wait_for_quotients();

        // sender idle profiles: light, heavy, none
        test_random_mix(210, 6);
        test_random_mix(210, 73);
        test_random_mix(212, 0);

        // catch any stray quotient beats after the last expected one
        repeat (Latency + 4) @(posedge clk);

        $display("Ran %0d divides (%0d clamped): directed edges, three sender pacings.",
                 beats_sent, saturations_seen);
        $display("Quotients compared: %0d, mismatches: %0d", quotients_checked, mismatches);
        if (pending_quotients.size() != 0)
        begin
            $error("quotient: %0d expected beats never arrived", pending_quotients.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/fdiv_pkg.sv
rtl/fdiv_step.sv
rtl/fixed_div_16_16_saturating.sv
rtl/fdiv_chk.sv
dv/fixed_div_16_16_saturating_tb.sv
